>>> design/bfla_pkg.sv
// Shared types and constants for the block free-list allocator.
`default_nettype none

package bfla_pkg;

  // Pool geometry. The field widths below are fixed by the block's ports.
  localparam int POOL_BLOCKS = 256;
  localparam int MAX_BATCH   = 64;

  localparam int ID_W    = 8;   // block id width
  localparam int DEPTH_W = 9;   // stack depth and block counts, 0 to POOL_BLOCKS
  localparam int COUNT_W = 7;   // allocate batch size
  localparam int ADDR_W  = 2;   // configuration byte address
  localparam int DATA_W  = 32;  // configuration data

  // Configuration register indexes.
  localparam int REG_ACTIVE_BLOCKS = 0;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OOM       = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

endpackage

`default_nettype wire

>>> design/block_free_list_allocator.sv
// Fixed-pool block allocator with a LIFO free-id stack and per-block allocated bits.
`default_nettype none

// A transaction is accepted on a rising edge with start high and busy low. An
// allocate of count blocks returns count results, one id per cycle, the first
// after a stack read, and stays busy until the last id is out; the rate is set
// by the single read port of the free-id stack, which yields one popped id a
// cycle. Free and query read the allocated-bit memory, then give the answer,
// and return one result. A pool reset, a zero or oversized count and an
// allocate that finds too few free blocks return one result from the idle
// state and never raise busy. Each result is shown for exactly one cycle with
// done high and must be taken then, since the receiver cannot stall the block.
// A pool reset, a write of active_blocks and the hardware reset all restore
// the pool: the allocated bits are cleared through a row of valid flags, and
// the stack bottom is tracked by a low-water mark, below which every entry
// still holds its own index. Configuration is written through an APB-style
// port whose writes ignore paddr; the user must write only while the block is
// idle, as the block does not enforce it. The value is clamped to 1 through 256.
module block_free_list_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Command channel.
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     cmd,
  input  wire logic [bfla_pkg::COUNT_W-1:0]   count,
  input  wire logic [bfla_pkg::ID_W-1:0]      req_id,
  // Result channel.
  output logic                                done,
  output logic [1:0]                          status,
  output logic [bfla_pkg::ID_W-1:0]           out_block_id,
  output logic                                is_alloc,
  output logic [bfla_pkg::DEPTH_W-1:0]        free_count,
  output logic [bfla_pkg::DEPTH_W-1:0]        used_count,
  output logic                                last,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bfla_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [bfla_pkg::DATA_W-1:0]    pwdata,
  output logic [bfla_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LOOK
  } state_t;

  localparam int ID_W    = bfla_pkg::ID_W;
  localparam int DEPTH_W = bfla_pkg::DEPTH_W;
  localparam int COUNT_W = bfla_pkg::COUNT_W;
  localparam int ADDR_W  = bfla_pkg::ADDR_W;
  localparam int NBLK    = bfla_pkg::POOL_BLOCKS;

  state_t               state, state_next;
  logic [DEPTH_W-1:0]   active;       // pool size register
  logic [DEPTH_W-1:0]   depth, depth_next;
  logic [DEPTH_W-1:0]   clean, clean_next;  // entries below this were never written
  logic [COUNT_W-1:0]   rem, rem_next;      // ids still to hand out
  logic [ID_W-1:0]      op_id;
  logic [1:0]           op_cmd;
  logic [ID_W-1:0]      pop_idx;
  logic                 pop_clean;

  // Memories.
  logic [ID_W-1:0]      stack_mem [NBLK];
  logic                 alloc_mem [NBLK];
  logic [ID_W-1:0]      stack_rdata;
  logic                 alloc_rdata;
  logic [NBLK-1:0]      alloc_valid;

  // Sequencer outputs.
  logic                 accept, cfg_write, pool_init;
  logic                 issue_pop;
  logic [DEPTH_W-1:0]   pop_addr;
  logic [ID_W-1:0]      popped_id;
  logic                 cur_bit;
  logic                 stack_we, alloc_we, alloc_wdata;
  logic [ID_W-1:0]      alloc_waddr;
  logic                 emit, emit_isal, emit_last;
  logic [1:0]           emit_status;
  logic [ID_W-1:0]      emit_id;
  logic [DEPTH_W-1:0]   emit_free;
  logic [DEPTH_W-1:0]   cfg_clamped;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  // Only the pool size register answers a read; other addresses read as zero.
  assign prdata    = (paddr == ADDR_W'(bfla_pkg::REG_ACTIVE_BLOCKS * 4)) ?
                     {{(bfla_pkg::DATA_W-DEPTH_W){1'b0}}, active} : '0;

  // Clamp the written pool size to 1 through the pool capacity.
  always_comb begin
    cfg_clamped = pwdata[DEPTH_W-1:0];
    if (cfg_clamped == '0) begin
      cfg_clamped = DEPTH_W'(1);
    end else if (cfg_clamped > DEPTH_W'(NBLK)) begin
      cfg_clamped = DEPTH_W'(NBLK);
    end
  end

  // The next stack read always targets the current top.
  assign pop_addr  = depth - DEPTH_W'(1);
  // An entry below the low-water mark still holds its own index.
  assign popped_id = pop_clean ? pop_idx : stack_rdata;
  assign cur_bit   = alloc_valid[op_id] && alloc_rdata;

  always_comb begin
    state_next  = state;
    depth_next  = depth;
    clean_next  = clean;
    rem_next    = rem;
    pool_init   = 1'b0;
    issue_pop   = 1'b0;
    stack_we    = 1'b0;
    alloc_we    = 1'b0;
    alloc_wdata = 1'b0;
    alloc_waddr = op_id;
    emit        = 1'b0;
    emit_status = bfla_pkg::ST_OK;
    emit_id     = '0;
    emit_isal   = 1'b0;
    emit_last   = 1'b1;
    emit_free   = depth;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            bfla_pkg::CMD_ALLOC: begin
              if (count == '0 || count > COUNT_W'(bfla_pkg::MAX_BATCH)) begin
                emit        = 1'b1;
                emit_status = bfla_pkg::ST_INVALID;
              end else if (depth < DEPTH_W'(count)) begin
                emit        = 1'b1;
                emit_status = bfla_pkg::ST_OOM;
              end else begin
                issue_pop  = 1'b1;
                rem_next   = count;
                state_next = S_POP;
              end
            end
            bfla_pkg::CMD_RESET: begin
              pool_init  = 1'b1;
              depth_next = active;
              clean_next = active;
              emit       = 1'b1;
              emit_free  = active;
            end
            bfla_pkg::CMD_FREE, bfla_pkg::CMD_QUERY: begin
              state_next = S_LOOK;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_POP: begin
        // Hand out the id read last cycle and, if more remain, read the next.
        alloc_we    = 1'b1;
        alloc_wdata = 1'b1;
        alloc_waddr = popped_id;
        emit        = 1'b1;
        emit_id     = popped_id;
        emit_last   = (rem == COUNT_W'(1));
        emit_free   = depth;
        rem_next    = rem - COUNT_W'(1);
        if (rem == COUNT_W'(1)) begin
          state_next = S_IDLE;
        end else begin
          issue_pop = 1'b1;
        end
      end

      S_LOOK: begin
        emit       = 1'b1;
        state_next = S_IDLE;
        if (op_cmd == bfla_pkg::CMD_QUERY) begin
          emit_isal = ({1'b0, op_id} < active) ? cur_bit : 1'b0;
        end else if ({1'b0, op_id} >= active) begin
          emit_status = bfla_pkg::ST_INVALID;
        end else if (!cur_bit) begin
          emit_status = bfla_pkg::ST_NOT_ALLOC;
        end else begin
          alloc_we = 1'b1;
          if (depth < DEPTH_W'(NBLK)) begin
            stack_we   = 1'b1;
            depth_next = depth + DEPTH_W'(1);
          end
          emit_free = depth_next;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (issue_pop) begin
      depth_next = pop_addr;
      clean_next = (pop_addr < clean) ? pop_addr : clean;
    end
  end

  // Sequencer state, pool registers and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      active      <= DEPTH_W'(NBLK);
      depth       <= DEPTH_W'(NBLK);
      clean       <= DEPTH_W'(NBLK);
      rem         <= '0;
      alloc_valid <= '0;
      done        <= 1'b0;
    end else if (cfg_write) begin
      // A register write restores the pool at the new size.
      active      <= cfg_clamped;
      depth       <= cfg_clamped;
      clean       <= cfg_clamped;
      alloc_valid <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      clean <= clean_next;
      rem   <= rem_next;
      done  <= emit;
      if (pool_init) begin
        alloc_valid <= '0;
      end else if (alloc_we) begin
        alloc_valid[alloc_waddr] <= 1'b1;
      end
    end

    if (accept) begin
      op_id  <= req_id;
      op_cmd <= cmd;
    end
    if (issue_pop) begin
      pop_idx   <= pop_addr[ID_W-1:0];
      pop_clean <= (pop_addr < clean);
    end
    status       <= emit_status;
    out_block_id <= emit_id;
    is_alloc     <= emit_isal;
    free_count   <= emit_free;
    used_count   <= active - emit_free;
    last         <= emit_last;
  end

  // Free-id stack and allocated-bit memory.
  always_ff @(posedge clk) begin
    stack_rdata <= stack_mem[pop_addr[ID_W-1:0]];
    alloc_rdata <= alloc_mem[req_id];
    if (stack_we) begin
      stack_mem[depth[ID_W-1:0]] <= op_id;
    end
    if (alloc_we) begin
      alloc_mem[alloc_waddr] <= alloc_wdata;
    end
  end

`ifndef ASSERT_OFF
  // The stack never holds more ids than the pool has blocks.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= active) else $error("stack depth exceeds pool size");

  // The low-water mark never rises above the current stack depth.
  a_clean_bound: assert property (@(posedge clk) disable iff (rst)
    clean <= depth) else $error("low-water mark above stack depth");

  // A result without last only occurs in the middle of an allocate burst.
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> state == S_POP) else $error("non-final result outside burst");

  // The final id of a burst is delivered as a last result and leaves the block idle.
  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    state == S_POP && rem == COUNT_W'(1) && !cfg_write |=> done && last && !busy)
    else $error("allocate burst did not end cleanly");
`endif

endmodule

`default_nettype wire
